[design/msk_pkg.sv]
// ----------------------------------------------------------------------------
// msk_pkg
// Shared constants for the multi-stack engine: field widths, command,
// status and configuration register codes.
// ----------------------------------------------------------------------------
package msk_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int SEL_W  = 2;
    localparam int STAT_W = 2;
    localparam int CAP_W  = 7;
    localparam int USE_W  = 3;
    localparam int CIDX_W = 3;
    localparam int NUM_CAP_REGS = 4;

    // Commands
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;

    // Result status
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADIDX   = 2'd3;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_STACKS_IN_USE = 3'd0;
    localparam logic [CIDX_W-1:0] REG_CAP_ZERO      = 3'd1;
    localparam logic [CIDX_W-1:0] REG_CAP_ONE       = 3'd2;
    localparam logic [CIDX_W-1:0] REG_CAP_TWO       = 3'd3;
    localparam logic [CIDX_W-1:0] REG_CAP_THREE     = 3'd4;

endpackage

[design/msk_store.sv]
// ----------------------------------------------------------------------------
// msk_store
// Shared word store for all stacks: one port, either a write or a read in a
// cycle, read data registered and held while no read is issued.
// ----------------------------------------------------------------------------
module msk_store
    import msk_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [AW-1:0]     i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/multi_stack_engine.sv]
// ----------------------------------------------------------------------------
// multi_stack_engine
// Several bounded stacks of 32-bit words held in one shared store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries cmd, stack_sel, value.
//   Output channel (o_out_valid / i_out_ready) carries status, data, last;
//   last marks the final result of a command.
//   Push, overflow, bad index and empty results appear in the output
//   register in the cycle after the transaction. Pop and list read the store,
//   whose read data is registered: the first word passes the store's read
//   register and then the output register; further list words follow one
//   per cycle while the receiver does not stall. The next command is taken
//   once the last result of the current one sits in the output register.
//   When the receiver stalls, the output register holds its result and the
//   engine waits; no transaction is taken while a result cannot be loaded.
//   Reset empties every stack and restores stacks_in_use = 4 and all
//   capacities to 64; store contents need no clearing.
//   Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_wdata) take effect at
//   once and are expected only while the engine is idle.
// ----------------------------------------------------------------------------
module multi_stack_engine
    import msk_pkg::*;
#(
    parameter int NUM_STACKS = 4,
    parameter int MAX_DEPTH  = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CIDX_W-1:0]        i_cfg_idx,
    input  logic [CAP_W-1:0]         i_cfg_wdata,
    // command channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic [SEL_W-1:0]         i_stack_sel,
    input  logic signed [DATA_W-1:0] i_value,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_last
);

    localparam int SW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int OW    = $clog2(MAX_DEPTH + 1);
    localparam int DEPTH = NUM_STACKS * MAX_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    // configuration registers
    logic [USE_W-1:0] r_stacks_in_use;
    logic [CAP_W-1:0] r_cap [NUM_CAP_REGS];

    // control state
    t_state           r_state, n_state;
    logic [OW-1:0]    r_occ [NUM_STACKS];
    logic [OW-1:0]    n_occ [NUM_STACKS];
    logic             r_is_list, n_is_list;
    logic [SW-1:0]    r_sel, n_sel;
    logic [AW-1:0]    r_base, n_base;
    logic [OW-1:0]    r_slot, n_slot;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic [DATA_W-1:0] r_data, n_data;
    logic              r_last, n_last;

    // store port
    logic              w_mem_we;
    logic              w_mem_re;
    logic [AW-1:0]     w_mem_addr;
    logic [DATA_W-1:0] w_mem_rdata;

    logic              w_out_free;
    logic              w_accept;
    logic [SW-1:0]     w_in_sel;
    logic [OW-1:0]     w_in_occ;
    logic [AW-1:0]     w_in_base;
    logic [CAP_W-1:0]  w_cap_eff;
    logic              w_bad;
    logic              w_full;

    msk_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_mem_re),
        .i_addr  (w_mem_addr),
        .i_wdata (i_value),
        .o_rdata (w_mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stacks_in_use <= USE_W'(4);
            for (int k = 0; k < NUM_CAP_REGS; k++) begin
                r_cap[k] <= CAP_W'(64);
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STACKS_IN_USE: r_stacks_in_use <= i_cfg_wdata[USE_W-1:0];
                REG_CAP_ZERO:      r_cap[0] <= i_cfg_wdata;
                REG_CAP_ONE:       r_cap[1] <= i_cfg_wdata;
                REG_CAP_TWO:       r_cap[2] <= i_cfg_wdata;
                REG_CAP_THREE:     r_cap[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_in_sel  = i_stack_sel[SW-1:0];
    assign w_in_occ  = r_occ[w_in_sel];
    assign w_in_base = AW'(int'(w_in_sel) * MAX_DEPTH);
    assign w_cap_eff = (r_cap[i_stack_sel] > CAP_W'(MAX_DEPTH)) ? CAP_W'(MAX_DEPTH)
                                                                : r_cap[i_stack_sel];
    assign w_bad  = ({1'b0, i_stack_sel} >= r_stacks_in_use)
                 || (int'(i_stack_sel) >= NUM_STACKS);
    assign w_full = CAP_W'(w_in_occ) >= w_cap_eff;

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_is_list   = r_is_list;
        n_sel       = r_sel;
        n_base      = r_base;
        n_slot      = r_slot;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_data      = r_data;
        n_last      = r_last;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_addr  = r_base + AW'(r_slot - OW'(1));

        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_cmd != CMD_RSVD)) begin
                    n_out_valid = 1'b1;
                    n_data      = '0;
                    n_last      = 1'b1;
                    n_sel       = w_in_sel;
                    n_base      = w_in_base;
                    if (w_bad) begin
                        n_status = ST_BADIDX;
                    end else begin
                        case (i_cmd)
                            CMD_PUSH: begin
                                if (w_full) begin
                                    n_status = ST_OVERFLOW;
                                end else begin
                                    n_status        = ST_OK;
                                    w_mem_we        = 1'b1;
                                    w_mem_addr      = w_in_base + AW'(w_in_occ);
                                    n_occ[w_in_sel] = w_in_occ + OW'(1);
                                end
                            end
                            CMD_POP, CMD_LIST: begin
                                if (w_in_occ == '0) begin
                                    n_status = ST_EMPTY;
                                end else begin
                                    // result comes from the store next cycle
                                    n_out_valid = 1'b0;
                                    w_mem_re    = 1'b1;
                                    w_mem_addr  = w_in_base + AW'(w_in_occ - OW'(1));
                                    n_slot      = w_in_occ - OW'(1);
                                    n_is_list   = (i_cmd == CMD_LIST);
                                    n_state     = S_READ;
                                    if (i_cmd == CMD_POP) begin
                                        n_occ[w_in_sel] = w_in_occ - OW'(1);
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_READ: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_data      = w_mem_rdata;
                    n_last      = !r_is_list || (r_slot == '0);
                    if (r_is_list && (r_slot != '0)) begin
                        // fetch the next word down while this one is shown
                        w_mem_re = 1'b1;
                        n_slot   = r_slot - OW'(1);
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_is_list   <= 1'b0;
            for (int k = 0; k < NUM_STACKS; k++) begin
                r_occ[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_is_list   <= n_is_list;
            r_occ       <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel    <= n_sel;
        r_base   <= n_base;
        r_slot   <= n_slot;
        r_status <= n_status;
        r_data   <= n_data;
        r_last   <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data      = r_data;
    assign o_last      = r_last;

    // no transaction while a result is stuck in the output register
    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("command taken while result stalled");

    // only a list run leaves a result without last
    a_not_last_is_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> ((r_state == S_READ) && r_is_list))
        else $error("non-final result outside a list run");

    // a list never walks above the stored elements
    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_READ) && r_is_list) |-> (r_slot < r_occ[r_sel]))
        else $error("list slot beyond occupancy");

    // single store port: never read and write together
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_we && w_mem_re))
        else $error("store read and write in one cycle");

endmodule
